// ===== rtl/tacf_pkg.sv =====
// ============================================================================
// Token-at-cursor finder package
// Shared widths, request codes and the controller/datapath signal groups.
// ============================================================================
package tacf_pkg;

    localparam int MAX_TOKENS_DEF = 1024;
    localparam int LINE_BITS_DEF  = 20;
    localparam int COL_BITS_DEF   = 16;

    localparam int IDX_BITS = 10;
    localparam int CNT_BITS = 11;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic REG_TOKEN_COUNT = 1'b0;

    typedef struct packed {
        logic load_wr;
        logic init;
        logic rd_en;
        logic rd_scan;
        logic bs_step;
        logic sc_step;
    } cmd_t;

    typedef struct packed {
        logic bad_query;
        logic lo_lt_hi;
        logic lo_lt_n;
        logic end_before;
        logic start_after;
        logic tok_str;
    } status_t;

endpackage

// ===== rtl/token_at_cursor_finder_top.sv =====
// ============================================================================
// Token-at-cursor finder
// Finds the source token under a cursor in a sorted table of token spans.
// ============================================================================
//
//  channel   | signals                                  | beat taken when
//  ----------+------------------------------------------+---------------------------
//  config    | psel penable pwrite paddr pwdata prdata  | psel & penable & pwrite
//  request   | start busy req_type ... query_missing    | start & !busy
//  result    | done token_number                        | done (one cycle)
//
//  A load beat writes the table in its accept cycle and leaves the block idle.
//  A query runs binary search probes and then scans entries forward; each
//  step is a table read on the single read port followed by a compare, and
//  the result beat follows the scan. A bad cursor skips the search and goes
//  straight to the result beat.
//  Reset is asynchronous and active low and clears token_count.
//  The receiver cannot stall: the result stands on the ports for one cycle.
//
module token_at_cursor_finder_top #(
    parameter int MAX_TOKENS = tacf_pkg::MAX_TOKENS_DEF,
    parameter int LINE_BITS  = tacf_pkg::LINE_BITS_DEF,
    parameter int COL_BITS   = tacf_pkg::COL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [tacf_pkg::IDX_BITS-1:0] entry_index,
    input  logic [LINE_BITS-1:0]          start_line,
    input  logic [COL_BITS-1:0]           start_col,
    input  logic [LINE_BITS-1:0]          end_line,
    input  logic [COL_BITS-1:0]           end_col,
    input  logic                          string_flag,
    input  logic [LINE_BITS-1:0]          query_line,
    input  logic [COL_BITS-1:0]           query_col,
    input  logic                          query_missing,
    output logic                          done,
    output logic [tacf_pkg::CNT_BITS-1:0] token_number
);

    import tacf_pkg::*;

    logic [CNT_BITS-1:0] token_count_reg;
    logic                cfg_wr;
    cmd_t                cmd;
    status_t             status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOKEN_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            token_count_reg <= pwdata[CNT_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TOKEN_COUNT) ? 32'(token_count_reg) : 32'd0;

    tacf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    tacf_dpath #(
        .MAX_TOKENS (MAX_TOKENS),
        .LINE_BITS  (LINE_BITS),
        .COL_BITS   (COL_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .token_count   (token_count_reg),
        .entry_index   (entry_index),
        .start_line    (start_line),
        .start_col     (start_col),
        .end_line      (end_line),
        .end_col       (end_col),
        .string_flag   (string_flag),
        .query_line    (query_line),
        .query_col     (query_col),
        .query_missing (query_missing),
        .token_number  (token_number)
    );

endmodule

// ===== rtl/tacf_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module tacf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tacf_ctrl.sv =====
// ============================================================================
// Token-at-cursor finder controller
// Issues load-beat table writes and sequences the binary search probes, the forward scan and the result beat.
// ============================================================================
module tacf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              req_type,
    input  tacf_pkg::status_t status,
    output tacf_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);

    import tacf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BS_CHK = 3'd1;
    localparam logic [2:0] ST_BS_CMP = 3'd2;
    localparam logic [2:0] ST_SC_CHK = 3'd3;
    localparam logic [2:0] ST_SC_CMP = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] st_reg;
    logic [2:0] st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        cmd     = '0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (start && (req_type == REQ_QUERY))
                begin
                    cmd.init = 1'b1;
                    st_next  = status.bad_query ? ST_DONE : ST_BS_CHK;
                end
                else if (start)
                begin
                    cmd.load_wr = 1'b1;
                end
            end
            ST_BS_CHK:
            begin
                if (status.lo_lt_hi)
                begin
                    cmd.rd_en = 1'b1;
                    st_next   = ST_BS_CMP;
                end
                else
                begin
                    st_next = ST_SC_CHK;
                end
            end
            ST_BS_CMP:
            begin
                cmd.bs_step = 1'b1;
                st_next     = ST_BS_CHK;
            end
            ST_SC_CHK:
            begin
                if (status.lo_lt_n)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_scan = 1'b1;
                    st_next     = ST_SC_CMP;
                end
                else
                begin
                    st_next = ST_DONE;
                end
            end
            ST_SC_CMP:
            begin
                if (status.start_after)
                begin
                    st_next = ST_DONE;
                end
                else
                begin
                    cmd.sc_step = 1'b1;
                    st_next     = status.tok_str ? ST_DONE : ST_SC_CHK;
                end
            end
            ST_DONE:
            begin
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (st_reg != ST_IDLE);
    assign done = (st_reg == ST_DONE);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result beat not followed by idle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_QUERY)) |=> busy)
        else $error("accepted query did not make the block busy");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_LOAD)) |=> !busy && !done)
        else $error("load beat started a search");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.bs_step || cmd.sc_step) |-> $past(cmd.rd_en))
        else $error("compare without a preceding table read");

endmodule

// ===== rtl/tacf_dpath.sv =====
// ============================================================================
// Token-at-cursor finder datapath
// Token table, search bounds, position compares and the chosen token number.
// ============================================================================
module tacf_dpath #(
    parameter int MAX_TOKENS = tacf_pkg::MAX_TOKENS_DEF,
    parameter int LINE_BITS  = tacf_pkg::LINE_BITS_DEF,
    parameter int COL_BITS   = tacf_pkg::COL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tacf_pkg::cmd_t                cmd,
    output tacf_pkg::status_t             status,
    input  logic [tacf_pkg::CNT_BITS-1:0] token_count,
    input  logic [tacf_pkg::IDX_BITS-1:0] entry_index,
    input  logic [LINE_BITS-1:0]          start_line,
    input  logic [COL_BITS-1:0]           start_col,
    input  logic [LINE_BITS-1:0]          end_line,
    input  logic [COL_BITS-1:0]           end_col,
    input  logic                          string_flag,
    input  logic [LINE_BITS-1:0]          query_line,
    input  logic [COL_BITS-1:0]           query_col,
    input  logic                          query_missing,
    output logic [tacf_pkg::CNT_BITS-1:0] token_number
);

    import tacf_pkg::*;

    localparam int AW     = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int WORD_W = 2 * LINE_BITS + 2 * COL_BITS + 1;
    localparam int EC_LO  = 1;
    localparam int EL_LO  = EC_LO + COL_BITS;
    localparam int SC_LO  = EL_LO + LINE_BITS;
    localparam int SL_LO  = SC_LO + COL_BITS;

    logic [LINE_BITS-1:0] qline_reg;
    logic [COL_BITS-1:0]  qcol_reg;
    logic [COL_BITS-1:0]  qcolm1_reg;
    logic [CNT_BITS-1:0]  lo_reg;
    logic [CNT_BITS-1:0]  lo_next;
    logic [CNT_BITS-1:0]  hi_reg;
    logic [CNT_BITS-1:0]  hi_next;
    logic [CNT_BITS-1:0]  n_reg;
    logic [CNT_BITS-1:0]  mid_reg;
    logic [CNT_BITS-1:0]  found_reg;
    logic [CNT_BITS-1:0]  found_next;
    logic [CNT_BITS-1:0]  mid;
    logic [CNT_BITS-1:0]  n_sat;
    logic [CNT_BITS-1:0]  lo_inc;

    logic                 wr_en;
    logic [AW-1:0]        raddr;
    logic [WORD_W-1:0]    wdata;
    logic [WORD_W-1:0]    rdata;

    logic [LINE_BITS-1:0] rd_start_line;
    logic [COL_BITS-1:0]  rd_start_col;
    logic [LINE_BITS-1:0] rd_end_line;
    logic [COL_BITS-1:0]  rd_end_col;

    assign wr_en = cmd.load_wr && (32'(entry_index) < MAX_TOKENS);
    assign wdata = {start_line, start_col, end_line, end_col, string_flag};
    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign raddr = cmd.rd_scan ? AW'(lo_reg) : AW'(mid);
    assign n_sat = (32'(token_count) > MAX_TOKENS) ? CNT_BITS'(MAX_TOKENS) : token_count;
    assign lo_inc = lo_reg + CNT_BITS'(1);

    tacf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_TOKENS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(entry_index)),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_start_line = rdata[SL_LO +: LINE_BITS];
    assign rd_start_col  = rdata[SC_LO +: COL_BITS];
    assign rd_end_line   = rdata[EL_LO +: LINE_BITS];
    assign rd_end_col    = rdata[EC_LO +: COL_BITS];

    always_comb
    begin
        status.bad_query   = query_missing || (query_col == '0);
        status.lo_lt_hi    = (lo_reg < hi_reg);
        status.lo_lt_n     = (lo_reg < n_reg);
        status.end_before  = (rd_end_line < qline_reg) ||
                             ((rd_end_line == qline_reg) && (rd_end_col < qcolm1_reg));
        status.start_after = (qline_reg < rd_start_line) ||
                             ((qline_reg == rd_start_line) && (qcol_reg < rd_start_col));
        status.tok_str     = rdata[0];
    end

    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        found_next = found_reg;
        if (cmd.init)
        begin
            lo_next    = '0;
            hi_next    = n_sat;
            found_next = '0;
        end
        else if (cmd.bs_step)
        begin
            if (status.end_before)
            begin
                lo_next = mid_reg + CNT_BITS'(1);
            end
            else
            begin
                hi_next = mid_reg;
            end
        end
        else if (cmd.sc_step)
        begin
            if ((found_reg == '0) || status.tok_str)
            begin
                found_next = lo_inc;
            end
            lo_next = lo_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg    <= '0;
            hi_reg    <= '0;
            found_reg <= '0;
        end
        else
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            qline_reg  <= query_line;
            qcol_reg   <= query_col;
            qcolm1_reg <= query_col - COL_BITS'(1);
            n_reg      <= n_sat;
        end
        if (cmd.rd_en && !cmd.rd_scan)
        begin
            mid_reg <= mid;
        end
    end

    assign token_number = found_reg;

endmodule
